// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the framebuffer modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define DTFB_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dtfb assertion failed");

// Condition must never be true outside reset.
`define DTFB_NEVER(name, clk, rst, cond) \
  `DTFB_ASSERT(name, clk, rst, !(cond))

`endif

// ----- sv/dtfb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfb_pkg
// Types, sizes and codes shared by the depth-tested framebuffer modules.
// ----------------------------------------------------------------------------
package dtfb_pkg;

  // Screen geometry.
  localparam int WIDTH  = 128;
  localparam int HEIGHT = 32;

  localparam int PIX_W  = 8;
  localparam int LANES  = 8;
  localparam int LANE_W = $clog2(LANES);
  localparam int PAGES  = (HEIGHT + LANES - 1) / LANES;
  localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int COL_W  = $clog2(WIDTH);
  localparam int ADDR_W = COL_W + PAGE_W;
  localparam int RAM_DEPTH = WIDTH * (1 << PAGE_W);
  localparam int ROW_W  = LANES * PIX_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_W     = 16;
  localparam int REG_IDX_W = 2;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_CAMERA_X       = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CAMERA_Y       = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DEFAULT_COLOUR = 2'd2;

  // Command codes on the input word.
  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_PLOT  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // Job codes after classification.
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_PLOT  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]         colour;
    logic [7:0]         depth;
    logic [6:0]         column;
    logic [1:0]         page;
  } cmd_t;

  typedef struct packed {
    logic [7:0] page_bits;
    logic       plotted;
  } rsp_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] addr;
    logic [LANE_W-1:0] lane;
    logic [PIX_W-1:0]  value;
    logic [7:0]        depth;
    logic [LANES-1:0]  mask;
  } job_t;

endpackage

// ----- sv/dtfb_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfb_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dtfb_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/dtfb_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfb_front
// Accepts command words, maps plot positions to screen cells and turns each
// word into a job for the back end.
// ----------------------------------------------------------------------------
module dtfb_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_stall,
  input  dtfb_pkg::cmd_t                 cmd,
  input  logic                           wr_en,
  input  logic [dtfb_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [dtfb_pkg::CFG_W-1:0]     wr_data,
  input  logic                           q_full,
  input  logic                           init_busy,
  output logic                           q_push,
  output dtfb_pkg::job_t                 q_job
);
  import dtfb_pkg::*;

  logic signed [15:0] camera_x;
  logic signed [15:0] camera_y;
  logic signed [17:0] tx;
  logic signed [17:0] ty;
  logic [13:0]        xcoord;
  logic [13:0]        ycoord;
  logic               on_screen;
  logic [PAGE_W-1:0]  plot_page;
  logic [PAGE_W-1:0]  read_page;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x <= '0;
      camera_y <= '0;
    end else if (wr_en) begin
      if (wr_index == REG_CAMERA_X) begin
        camera_x <= wr_data;
      end
      if (wr_index == REG_CAMERA_Y) begin
        camera_y <= wr_data;
      end
    end
  end

  // Position minus camera plus one half, still in sixteenths of a pixel.
  assign tx = {{2{cmd.pos_x[15]}}, cmd.pos_x} - {{2{camera_x[15]}}, camera_x} + 18'sd8;
  assign ty = {{2{cmd.pos_y[15]}}, cmd.pos_y} - {{2{camera_y[15]}}, camera_y} + 18'sd8;

  // Truncation toward zero sends anything in (-1, 0) to cell zero.
  assign xcoord = tx[17] ? 14'd0 : tx[17:4];
  assign ycoord = ty[17] ? 14'd0 : ty[17:4];

  assign on_screen = (tx > -18'sd16) && (ty > -18'sd16) &&
                     (xcoord < 14'(WIDTH)) && (ycoord < 14'(HEIGHT));

  assign plot_page = PAGE_W'(ycoord[13:LANE_W]);
  assign read_page = PAGE_W'(cmd.page);

  assign cmd_stall = q_full || init_busy;
  assign q_push    = cmd_valid && !cmd_stall;

  always_comb begin
    q_job       = '0;
    q_job.depth = cmd.depth;
    q_job.value = cmd.colour + {cmd.depth[6:0], 1'b0};
    unique case (cmd.func)
      FUNC_CLEAR: begin
        q_job.op = OP_CLEAR;
      end
      FUNC_PLOT: begin
        q_job.op   = (on_screen && (cmd.colour != 8'd0)) ? OP_PLOT : OP_NONE;
        q_job.addr = {COL_W'(xcoord), plot_page};
        q_job.lane = ycoord[LANE_W-1:0];
      end
      FUNC_READ: begin
        q_job.op   = ({25'd0, cmd.column} < WIDTH) ? OP_READ : OP_NONE;
        q_job.addr = {COL_W'(cmd.column), read_page};
        for (int k = 0; k < LANES; k++) begin
          q_job.mask[k] = (int'(cmd.page) * LANES + k) < HEIGHT;
        end
      end
      default: begin
        q_job.op = OP_NONE;
      end
    endcase
  end

endmodule

// ----- sv/dtfb_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfb_queue
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dtfb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_push,
  input  dtfb_pkg::job_t q_job_in,
  output logic           q_full,
  input  logic           q_pop,
  output logic           q_empty,
  output dtfb_pkg::job_t q_job_out
);
  import dtfb_pkg::*;

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign q_full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_empty   = (count == '0);
  assign q_job_out = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (q_push) begin
        wptr <= bump(wptr);
      end
      if (q_pop) begin
        rptr <= bump(rptr);
      end
      if (q_push && !q_pop) begin
        count <= count + 1'b1;
      end else if (q_pop && !q_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      slots[wptr] <= q_job_in;
    end
  end

  `DTFB_NEVER(a_push_when_full, clk, rst, q_push && q_full)
  `DTFB_NEVER(a_pop_when_empty, clk, rst, q_pop && q_empty)

endmodule

// ----- sv/dtfb_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfb_back
// Executes jobs against the pixel store: clear sweeps, depth-tested plots
// as read-modify-write of one eight-pixel row, and page reads.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dtfb_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [dtfb_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [dtfb_pkg::CFG_W-1:0]     wr_data,
  input  logic                           q_empty,
  input  dtfb_pkg::job_t                 q_job,
  output logic                           q_pop,
  output logic                           init_busy,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output dtfb_pkg::rsp_t                 rsp
);
  import dtfb_pkg::*;

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LOOK  = 3'd2;
  localparam logic [2:0] ST_SWEEP = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [ADDR_W-1:0] count;
  logic [ADDR_W-1:0] count_next;
  logic              default_colour;
  job_t              job;
  rsp_t              res;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ROW_W-1:0]  ram_wdata;
  logic [ROW_W-1:0]  rdata;

  logic              out_free;
  logic              fin;
  rsp_t              fin_rsp;
  logic [PIX_W-1:0]  stored;
  logic [PIX_W-1:0]  stored_m1;
  logic [6:0]        sdepth;
  logic              win;
  logic [ROW_W-1:0]  new_row;
  logic [LANES-1:0]  bits;
  logic              sweep_last;

  dtfb_ram #(
    .DATA_W (ROW_W),
    .DEPTH  (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (q_job.addr),
    .rdata (rdata)
  );

  assign out_free   = !rsp_valid || !rsp_stall;
  assign q_pop      = (state == ST_IDLE) && !q_empty;
  assign init_busy  = (state == ST_INIT);
  assign sweep_last = (count == ADDR_W'(RAM_DEPTH - 1));

  // A stored zero counts as depth zero.
  assign stored    = rdata[job.lane * PIX_W +: PIX_W];
  assign stored_m1 = stored - 1'b1;
  assign sdepth    = (stored == '0) ? 7'd0 : stored_m1[7:1];
  assign win       = (job.op == OP_PLOT) && ({1'b0, sdepth} <= job.depth);

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      new_row[l*PIX_W +: PIX_W] = (LANE_W'(l) == job.lane) ? job.value
                                                           : rdata[l*PIX_W +: PIX_W];
      bits[l] = job.mask[l] & (rdata[l*PIX_W] ^ default_colour);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count;
    ram_wdata = '0;
    unique case (state) inside
      ST_INIT, ST_SWEEP: begin
        ram_we = 1'b1;
      end
      ST_LOOK: begin
        ram_we    = win;
        ram_waddr = job.addr;
        ram_wdata = new_row;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    count_next = count;
    fin        = 1'b0;
    fin_rsp    = '0;
    unique case (state)
      ST_INIT: begin
        count_next = count + 1'b1;
        if (sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          unique case (q_job.op) inside
            OP_CLEAR: begin
              state_next = ST_SWEEP;
              count_next = '0;
            end
            OP_PLOT, OP_READ: begin
              state_next = ST_LOOK;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      ST_LOOK: begin
        fin               = 1'b1;
        fin_rsp.plotted   = win;
        fin_rsp.page_bits = (job.op == OP_READ) ? bits : 8'd0;
      end
      ST_SWEEP: begin
        count_next = count + 1'b1;
        fin        = sweep_last;
      end
      ST_EMIT: begin
        fin     = 1'b1;
        fin_rsp = res;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (fin) begin
      state_next = out_free ? ST_IDLE : ST_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_INIT;
      count          <= '0;
      rsp_valid      <= 1'b0;
      default_colour <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (fin && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (wr_en && (wr_index == REG_DEFAULT_COLOUR)) begin
        default_colour <= wr_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_job;
    end
    if (fin && out_free) begin
      rsp <= fin_rsp;
    end
    if (fin && !out_free) begin
      res <= fin_rsp;
    end
  end

  `DTFB_ASSERT(a_look_after_idle, clk, rst,
               (state == ST_LOOK) |-> ($past(state) == ST_IDLE))
  `DTFB_NEVER(a_no_write_in_emit, clk, rst, (state == ST_EMIT) && ram_we)
  `DTFB_ASSERT(a_queue_empty_at_init, clk, rst, (state == ST_INIT) |-> q_empty)

endmodule

// ----- sv/depth_tested_framebuffer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_tested_framebuffer
// Monochrome framebuffer of 8-bit pixel words with camera offset, depth test
// on plot and page-byte read-out for the display.
// ----------------------------------------------------------------------------
//  Channel  Signals                        Direction  Word
//  cmd      cmd_valid, cmd_stall, cmd      in         cmd_t
//  rsp      rsp_valid, rsp_stall, rsp      out        rsp_t
//  config   wr_en, wr_index, wr_data       in         16-bit register data
//
// Plot and read run in the back end as one store read, then the write-back
// of the eight-pixel row and the result. Clear sweeps the store one row per
// cycle, all 512 rows at 128 x 32. After reset the same sweep runs and
// cmd_stall stays high until it is done. A short queue lets the front end
// keep taking words while the back end waits on a stalled rsp channel.
// ----------------------------------------------------------------------------
module depth_tested_framebuffer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_stall,
  input  dtfb_pkg::cmd_t                 cmd,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output dtfb_pkg::rsp_t                 rsp,
  input  logic                           wr_en,
  input  logic [dtfb_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [dtfb_pkg::CFG_W-1:0]     wr_data
);
  import dtfb_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  logic init_busy;
  job_t job_in;
  job_t job_out;

  dtfb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .q_full    (q_full),
    .init_busy (init_busy),
    .q_push    (q_push),
    .q_job     (job_in)
  );

  dtfb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .q_push    (q_push),
    .q_job_in  (job_in),
    .q_full    (q_full),
    .q_pop     (q_pop),
    .q_empty   (q_empty),
    .q_job_out (job_out)
  );

  dtfb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .q_empty   (q_empty),
    .q_job     (job_out),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
